// ===== rtl/mecv_pkg.sv =====
`timescale 1ns / 1ps
package mecv_pkg;

   localparam int CHANNELS = 4;
   localparam int WORD_W   = 32;
   localparam int PROD_W   = 64;

   localparam logic [1:0] MODE_UPDATE   = 2'd0;
   localparam logic [1:0] MODE_ZERO_ONE = 2'd1;
   localparam logic [1:0] MODE_CAPTURE  = 2'd2;
   localparam logic [1:0] MODE_ZERO_ALL = 2'd3;

   localparam logic [1:0] CSR_WIDE_MASK   = 2'd0;
   localparam logic [1:0] CSR_INVERT_MASK = 2'd1;
   localparam logic [1:0] CSR_RPM_SCALE   = 2'd2;

   localparam logic [CHANNELS-1:0] WIDE_MASK_RESET   = 4'd9;
   localparam logic [CHANNELS-1:0] INVERT_MASK_RESET = 4'd4;
   localparam logic [WORD_W-1:0]   RPM_SCALE_RESET   = 32'd393216;

   typedef enum logic [1:0] {
      ACT_HOLD    = 2'd0,
      ACT_UPDATE  = 2'd1,
      ACT_ZERO    = 2'd2,
      ACT_CAPTURE = 2'd3
   } act_type;

   typedef struct packed {
      logic accept;
      logic move12;
      logic move2o;
      logic out_hold;
   } pipe_ctl_type;

   typedef struct packed {
      act_type                   act;
      logic signed [PROD_W-1:0]  product;
      logic signed [WORD_W-1:0]  position;
   } lane_res_type;

   function automatic logic signed [WORD_W-1:0] sat_speed(input logic signed [PROD_W-1:0] p);
      logic signed [WORD_W-1:0] r;
      if ((&p[PROD_W-1:WORD_W-1]) || !(|p[PROD_W-1:WORD_W-1])) begin
         r = p[WORD_W-1:0];
      end else if (p[PROD_W-1]) begin
         r = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(WORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/multi_encoder_count_velocity_core.sv =====
`timescale 1ns / 1ps
// Four-channel encoder position and speed tracker.
// Request channel (req_*): one control tick per transfer, carrying a mode,
// a channel number and four raw counter snapshots. Response channel (rsp_*):
// exactly one transfer per tick with all four positions and speeds after it.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// Path: a tick passes the snapshot difference and position update, the scale
// multiply, and saturation with the output register before it is shown on
// rsp_*; its response transfers once rsp_stall is low.
// Throughput: one tick per cycle while req_stall is low; positions and
// snapshots update in the first stage, so consecutive ticks need no spacing.
// When rsp_stall is held, the response stays put and the two internal stages
// fill; req_stall rises once all three stages hold ticks.
// Reset clears positions, speeds, snapshots and pipeline, and loads
// wide_mask = 9, invert_mask = 4, rpm_scale = 6.0 (Q16.16).
// csr_*: write-only registers, index 0 wide_mask, 1 invert_mask, 2 rpm_scale;
// write only while no tick is in flight.
module multi_encoder_count_velocity_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [1:0]         req_channel,
   input  logic [31:0]        req_raw_a,
   input  logic [31:0]        req_raw_b,
   input  logic [31:0]        req_raw_c,
   input  logic [31:0]        req_raw_d,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_position_a,
   output logic signed [31:0] rsp_position_b,
   output logic signed [31:0] rsp_position_c,
   output logic signed [31:0] rsp_position_d,
   output logic signed [31:0] rsp_speed_a,
   output logic signed [31:0] rsp_speed_b,
   output logic signed [31:0] rsp_speed_c,
   output logic signed [31:0] rsp_speed_d
);
   import mecv_pkg::*;

   logic [CHANNELS-1:0]      wide_ff;
   logic [CHANNELS-1:0]      invert_ff;
   logic [WORD_W-1:0]        scale_ff;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     out_free, s2_free, s1_free;
   pipe_ctl_type             ctl;
   act_type                  lane_act [CHANNELS];
   logic [WORD_W-1:0]        lane_raw [CHANNELS];
   lane_res_type             lane_res [CHANNELS];
   logic signed [WORD_W-1:0] position [CHANNELS];
   logic signed [WORD_W-1:0] speed [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff   <= WIDE_MASK_RESET;
         invert_ff <= INVERT_MASK_RESET;
         scale_ff  <= RPM_SCALE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WIDE_MASK:   wide_ff   <= csr_data[CHANNELS-1:0];
            CSR_INVERT_MASK: invert_ff <= csr_data[CHANNELS-1:0];
            CSR_RPM_SCALE:   scale_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   always_comb begin
      ctl.accept   = req_valid && s1_free;
      ctl.move12   = s1_valid_ff && s2_free;
      ctl.move2o   = s2_valid_ff && out_free;
      ctl.out_hold = rsp_stall;
      s1_valid_in  = ctl.accept || (s1_valid_ff && !ctl.move12);
      s2_valid_in  = ctl.move12 || (s2_valid_ff && !ctl.move2o);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   assign lane_raw[0] = req_raw_a;
   assign lane_raw[1] = req_raw_b;
   assign lane_raw[2] = req_raw_c;
   assign lane_raw[3] = req_raw_d;

   always_comb begin
      for (int n = 0; n < CHANNELS; n++) begin
         case (req_mode)
            MODE_UPDATE:   lane_act[n] = ACT_UPDATE;
            MODE_ZERO_ONE: lane_act[n] = (req_channel == 2'(n)) ? ACT_ZERO : ACT_HOLD;
            MODE_CAPTURE:  lane_act[n] = ACT_CAPTURE;
            default:       lane_act[n] = ACT_ZERO;
         endcase
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      mecv_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .req_act (lane_act[g]),
         .req_raw (lane_raw[g]),
         .wide    (wide_ff[g]),
         .invert  (invert_ff[g]),
         .scale   (scale_ff),
         .res     (lane_res[g])
      );
   end

   mecv_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .lane_res  (lane_res),
      .rsp_valid (rsp_valid),
      .position  (position),
      .speed     (speed)
   );

   assign rsp_position_a = position[0];
   assign rsp_position_b = position[1];
   assign rsp_position_c = position[2];
   assign rsp_position_d = position[3];
   assign rsp_speed_a    = speed[0];
   assign rsp_speed_b    = speed[1];
   assign rsp_speed_c    = speed[2];
   assign rsp_speed_d    = speed[3];

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_s1_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !ctl.move12) |=> s1_valid_ff)
      else $error("first stage tick lost");

   a_s2_kept: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !ctl.move2o) |=> s2_valid_ff)
      else $error("second stage tick lost");

   a_move_reaches_out: assert property (@(posedge clock) disable iff (reset)
      ctl.move2o |=> rsp_valid)
      else $error("response missing after stage two transfer");

endmodule

// ===== rtl/mecv_lane.sv =====
`timescale 1ns / 1ps
module mecv_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  mecv_pkg::pipe_ctl_type        ctl,
   input  mecv_pkg::act_type             req_act,
   input  logic [mecv_pkg::WORD_W-1:0]   req_raw,
   input  logic                          wide,
   input  logic                          invert,
   input  logic [mecv_pkg::WORD_W-1:0]   scale,
   output mecv_pkg::lane_res_type        res
);
   import mecv_pkg::*;

   logic [WORD_W-1:0]        snap_ff, snap_in;
   logic [WORD_W-1:0]        pos_ff, pos_in;
   logic [WORD_W-1:0]        raw_diff, ext_diff, diff_in;
   logic [WORD_W-1:0]        diff1_ff;
   logic [WORD_W-1:0]        pos1_ff;
   act_type                  act1_ff;
   logic signed [PROD_W-1:0] product_in;
   lane_res_type             res_ff;

   always_comb begin
      raw_diff = req_raw - snap_ff;
      ext_diff = wide ? raw_diff : {{16{raw_diff[15]}}, raw_diff[15:0]};
      diff_in  = invert ? (32'd0 - ext_diff) : ext_diff;
      pos_in   = pos_ff;
      snap_in  = snap_ff;
      case (req_act)
         ACT_UPDATE: begin
            pos_in  = invert ? (pos_ff - ext_diff) : (pos_ff + ext_diff);
            snap_in = req_raw;
         end
         ACT_ZERO: begin
            pos_in  = '0;
            snap_in = '0;
         end
         ACT_CAPTURE: begin
            pos_in  = '0;
            snap_in = req_raw;
         end
         default: begin
            pos_in  = pos_ff;
            snap_in = snap_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff <= '0;
         pos_ff  <= '0;
      end else if (ctl.accept) begin
         snap_ff <= snap_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         diff1_ff <= diff_in;
         pos1_ff  <= pos_in;
         act1_ff  <= req_act;
      end
   end

   assign product_in = $signed({diff1_ff[WORD_W-1], diff1_ff}) * $signed({1'b0, scale});

   always_ff @(posedge clock) begin
      if (ctl.move12) begin
         res_ff.act      <= act1_ff;
         res_ff.product  <= product_in;
         res_ff.position <= $signed(pos1_ff);
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/mecv_merge.sv =====
`timescale 1ns / 1ps
module mecv_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  mecv_pkg::pipe_ctl_type              ctl,
   input  mecv_pkg::lane_res_type              lane_res [mecv_pkg::CHANNELS],
   output logic                                rsp_valid,
   output logic signed [mecv_pkg::WORD_W-1:0]  position [mecv_pkg::CHANNELS],
   output logic signed [mecv_pkg::WORD_W-1:0]  speed [mecv_pkg::CHANNELS]
);
   import mecv_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [WORD_W-1:0] speed_ff [CHANNELS];
   logic signed [WORD_W-1:0] speed_in [CHANNELS];
   logic signed [WORD_W-1:0] pos_ff [CHANNELS];

   assign valid_in = ctl.move2o | (valid_ff & ctl.out_hold);

   always_comb begin
      for (int n = 0; n < CHANNELS; n++) begin
         case (lane_res[n].act)
            ACT_UPDATE:  speed_in[n] = sat_speed(lane_res[n].product);
            ACT_HOLD:    speed_in[n] = speed_ff[n];
            default:     speed_in[n] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int n = 0; n < CHANNELS; n++) begin
            speed_ff[n] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (ctl.move2o) begin
            for (int n = 0; n < CHANNELS; n++) begin
               speed_ff[n] <= speed_in[n];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.move2o) begin
         for (int n = 0; n < CHANNELS; n++) begin
            pos_ff[n] <= lane_res[n].position;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign position  = pos_ff;
   assign speed     = speed_ff;

endmodule
